>>> hw/rtl/serial_line_assembler_defines.svh
// Assertion helpers for the checker file.
`ifndef SERIAL_LINE_ASSEMBLER_DEFINES_SVH
`define SERIAL_LINE_ASSEMBLER_DEFINES_SVH

// Property checked outside reset only.
`define SLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SLA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/sla_pkg.sv
package sla_pkg;

  localparam int unsigned LineSizeDef = 64;
  localparam int unsigned CharW       = 8;
  localparam int unsigned OvfW        = 16;

  localparam logic [CharW-1:0] ChCr = 8'd13;
  localparam logic [CharW-1:0] ChLf = 8'd10;

  localparam logic [OvfW-1:0] OvfMax = '1;

  // Bank release from the readout side back to the assembler.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [3:0] {
    BkIdle = 4'b0001,
    BkRead = 4'b0010,
    BkLoad = 4'b0100,
    BkSend = 4'b1000
  } bk_state_e;

endpackage

>>> hw/rtl/sla_queue.sv
module sla_queue #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [DataW-1:0] pop_data_o
);

  logic [DataW-1:0] entry_q [2];
  logic             wp_q, wp_d;
  logic             rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i  ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= push_data_i;
    end
  end

  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = entry_q[rp_q];

endmodule

>>> hw/rtl/sla_line_buf.sv
module sla_line_buf #(
  parameter int unsigned AddrW = 7
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [AddrW-1:0]        wr_addr_i,
  input  logic [sla_pkg::CharW-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [AddrW-1:0]        rd_addr_i,
  output logic [sla_pkg::CharW-1:0] rd_data_o
);
  import sla_pkg::*;

  localparam int unsigned Depth = 2 ** AddrW;

  logic [CharW-1:0] mem_q [Depth];
  logic [CharW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/sla_front.sv
module sla_front #(
  parameter int unsigned LINE_SIZE = 64,
  parameter int unsigned IdxW      = 6,
  parameter int unsigned DescW     = 23
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sla_pkg::CharW-1:0] in_byte_i,
  input  sla_pkg::rel_t             rel_i,
  output logic                      wr_en_o,
  output logic [IdxW:0]             wr_addr_o,
  output logic [sla_pkg::CharW-1:0] wr_data_o,
  output logic                      push_o,
  output logic [DescW-1:0]          push_data_o
);
  import sla_pkg::*;

  localparam logic [IdxW-1:0] FillMax = IdxW'(LINE_SIZE - 1);

  logic [IdxW-1:0] fill_q, fill_d;
  logic            bank_q, bank_d;
  logic            disc_q, disc_d;
  logic [OvfW-1:0] ovf_q, ovf_d;
  logic [1:0]      busy_q, busy_d;
  logic            acc;
  logic            is_cr;
  logic            is_lf;

  // A bank stays busy from the end of its line until its last beat is sent.
  assign in_ready_o = ~busy_q[bank_q];
  assign acc        = in_valid_i & in_ready_o;
  assign is_cr      = (in_byte_i == ChCr);
  assign is_lf      = (in_byte_i == ChLf);

  always_comb begin
    fill_d  = fill_q;
    bank_d  = bank_q;
    disc_d  = disc_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    wr_en_o = 1'b0;
    push_o  = 1'b0;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (acc && !is_cr) begin
      if (is_lf) begin
        if (!disc_q && fill_q != '0) begin
          push_o         = 1'b1;
          busy_d[bank_q] = 1'b1;
          bank_d         = ~bank_q;
        end
        disc_d = 1'b0;
        fill_d = '0;
      end else if (!disc_q) begin
        if (fill_q < FillMax) begin
          wr_en_o = 1'b1;
          fill_d  = fill_q + IdxW'(1);
        end else begin
          // The byte that finds the store full is dropped with the line.
          if (ovf_q != OvfMax) begin
            ovf_d = ovf_q + OvfW'(1);
          end
          disc_d = 1'b1;
          fill_d = '0;
        end
      end
    end
  end

  assign wr_addr_o   = {bank_q, fill_q};
  assign wr_data_o   = in_byte_i;
  assign push_data_o = {bank_q, fill_q, ovf_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
      disc_q <= 1'b0;
      ovf_q  <= '0;
      busy_q <= '0;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
      disc_q <= disc_d;
      ovf_q  <= ovf_d;
      busy_q <= busy_d;
    end
  end

endmodule

>>> hw/rtl/sla_back.sv
module sla_back #(
  parameter int unsigned IdxW  = 6,
  parameter int unsigned DescW = 23
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  logic [DescW-1:0]          desc_i,
  output logic                      pop_o,
  output logic                      rd_en_o,
  output logic [IdxW:0]             rd_addr_o,
  input  logic [sla_pkg::CharW-1:0] rd_data_i,
  output sla_pkg::rel_t             rel_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sla_pkg::CharW-1:0] out_char_o,
  output logic                      out_last_o,
  output logic [sla_pkg::OvfW-1:0]  out_ovf_o
);
  import sla_pkg::*;

  bk_state_e        state_q, state_d;
  logic             bank_q, bank_d;
  logic [IdxW-1:0]  len_q, len_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [OvfW-1:0]  ovf_q, ovf_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    len_d   = len_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    char_d  = char_q;
    last_d  = last_q;
    valid_d = valid_q;
    pop_o   = 1'b0;
    rd_en_o = 1'b0;
    rel_o   = '0;
    case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          {bank_d, len_d, ovf_d} = desc_i;
          idx_d   = '0;
          state_d = BkRead;
        end
      end
      BkRead: begin
        rd_en_o = 1'b1;
        state_d = BkLoad;
      end
      BkLoad: begin
        char_d  = rd_data_i;
        last_d  = (idx_q == len_q - IdxW'(1));
        valid_d = 1'b1;
        state_d = BkSend;
      end
      BkSend: begin
        if (out_ready_i) begin
          valid_d = 1'b0;
          if (last_q) begin
            rel_o.valid = 1'b1;
            rel_o.bank  = bank_q;
            state_d     = BkIdle;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = BkRead;
          end
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  assign rd_addr_o   = {bank_q, idx_q};
  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign out_ovf_o   = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    ovf_q  <= ovf_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

>>> hw/rtl/serial_line_assembler.sv
// Assembles received serial bytes into text lines.
// Input stream: one byte per beat on s_axis. Carriage return is dropped; newline ends
// the line. Output stream: each non-empty line leaves on m_axis as one beat per
// character, tlast on the final one, with the overflow total beside every character.
// A line longer than LINE_SIZE-1 characters is dropped up to its newline and the
// 16-bit overflow total rises by one, stopping at 65535.
// The input takes one byte per cycle. Lines sit in two banks of the line buffer;
// the readout of one bank overlaps with assembly into the other. Input stalls
// only when the assembler wants a bank whose line has not been fully sent.
// Readout takes each character through a buffer read, an output register load and a
// send, set by the single read port and the output register; the next character is
// not read until the current one has been sent.
// When the receiver stalls, the held beat stays on m_axis and the readout waits;
// assembly continues until both banks hold finished lines.
// Reset clears the line fill, discard mode, the overflow total, and the queue of
// finished lines; buffer contents need no clearing.
module serial_line_assembler #(
  parameter int unsigned LINE_SIZE = sla_pkg::LineSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] line_char, [23:8] overflow_count
  output logic        m_axis_tlast_o    // last_of_line
);
  import sla_pkg::*;

  localparam int unsigned IdxW  = $clog2(LINE_SIZE);
  localparam int unsigned DescW = 1 + IdxW + OvfW;

  logic             wr_en;
  logic [IdxW:0]    wr_addr;
  logic [CharW-1:0] wr_data;
  logic             rd_en;
  logic [IdxW:0]    rd_addr;
  logic [CharW-1:0] rd_data;
  logic             push;
  logic [DescW-1:0] push_data;
  logic             pop;
  logic             empty;
  logic [DescW-1:0] pop_data;
  rel_t             rel;
  logic [CharW-1:0] out_char;
  logic [OvfW-1:0]  out_ovf;

  sla_front #(
    .LINE_SIZE(LINE_SIZE),
    .IdxW     (IdxW),
    .DescW    (DescW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .rel_i      (rel),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push),
    .push_data_o(push_data)
  );

  sla_line_buf #(
    .AddrW(IdxW + 1)
  ) u_buf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  sla_queue #(
    .DataW(DescW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (pop_data)
  );

  sla_back #(
    .IdxW (IdxW),
    .DescW(DescW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .desc_i     (pop_data),
    .pop_o      (pop),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .rel_o      (rel),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_char_o (out_char),
    .out_last_o (m_axis_tlast_o),
    .out_ovf_o  (out_ovf)
  );

  assign m_axis_tdata_o = {out_ovf, out_char};

endmodule

>>> hw/rtl/sla_checker.sv
`include "serial_line_assembler_defines.svh"

module sla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);
  import sla_pkg::*;

  logic        out_acc;
  logic        seen_q;
  logic [15:0] last_ovf_q;

  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_ovf_q <= '0;
    end else if (out_acc) begin
      seen_q     <= 1'b1;
      last_ovf_q <= m_axis_tdata_o[23:8];
    end
  end

  // Reset leaves the output register empty from the next edge on.
  `SLA_ASSERT_ALL(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "output valid during reset")

  // A stalled beat keeps its character, marker and count.
  `SLA_ASSERT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled beat changed")

  // Line delimiters never reach the output.
  `SLA_ASSERT(a_no_delim, out_acc |-> m_axis_tdata_o[7:0] != ChLf && m_axis_tdata_o[7:0] != ChCr, "delimiter in line output")

  // The overflow total only grows from beat to beat.
  `SLA_ASSERT(a_ovf_mono, out_acc && seen_q |-> m_axis_tdata_o[23:8] >= last_ovf_q, "overflow count went down")

endmodule

bind serial_line_assembler sla_checker u_sla_checker (.*);

>>> verif/tb_serial_line_assembler.sv
`timescale 1ns / 100ps

module tb_serial_line_assembler;
  import sla_pkg::*;

  localparam int unsigned LineSize   = sla_pkg::LineSizeDef;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainWait  = 32;

  typedef struct packed {
    logic [OvfW-1:0]  ovf;
    logic             last;
    logic [CharW-1:0] ch;
  } line_char_t;

  typedef enum int {
    LkShort,
    LkFull,
    LkOverflow,
    LkNoise
  } line_kind_e;

  // Tracks line assembly and keeps the characters that still have to leave the block.
  class line_tracker;
    line_char_t       pending_chars[$];
    logic [CharW-1:0] partial_line[$];
    bit               discarding;
    logic [OvfW-1:0]  ovf_total = '0;
    int unsigned      errors;
    int unsigned      lines_done;
    int unsigned      chars_checked;

    function void accept_rx_byte(logic [CharW-1:0] rx);
      line_char_t c;
      if (rx == ChCr) begin
        return;
      end
      if (rx == ChLf) begin
        if (!discarding) begin
          foreach (partial_line[k]) begin
            c.ch   = partial_line[k];
            c.last = (k == partial_line.size() - 1);
            c.ovf  = ovf_total;
            pending_chars.push_back(c);
          end
          if (partial_line.size() > 0) lines_done++;
        end
        discarding = 1'b0;
        partial_line.delete();
        return;
      end
      if (discarding) begin
        return;
      end
      if (partial_line.size() < LineSize - 1) begin
        partial_line.push_back(rx);
      end else begin
        // The byte that finds the store full is dropped along with the line.
        if (ovf_total != OvfMax) ovf_total++;
        discarding = 1'b1;
        partial_line.delete();
      end
    endfunction

    function void check_tx_char(logic [23:0] data, logic last);
      line_char_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char beat, actual data %h last %b", $time, data, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (data[7:0] != want.ch) begin
        $display("%0t: line_char mismatch, expected %h actual %h", $time, want.ch, data[7:0]);
        errors++;
      end
      if (last != want.last) begin
        $display("%0t: last_of_line mismatch, expected %b actual %b", $time, want.last, last);
        errors++;
      end
      if (data[23:8] != want.ovf) begin
        $display("%0t: overflow_count mismatch, expected %0d actual %0d",
                 $time, want.ovf, data[23:8]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  line_tracker tracker = new();
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 66;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  always #6 clk_i = ~clk_i;

  serial_line_assembler #(
    .LINE_SIZE(LineSize)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  // Receiver: random back-pressure, and every accepted beat goes to the checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_tx_char(m_axis_tdata_o, m_axis_tlast_o);
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout after %0d cycles without a beat", QuietLimit);
    $display("tb_serial_line_assembler failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rx;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.accept_rx_byte(rx);
    if (rx != ChCr) items_sent++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ChCr || b == ChLf);
    return b;
  endfunction

  task automatic send_line(input line_kind_e kind);
    int unsigned len;
    int unsigned n;
    len = 0;
    case (kind)
      LkShort:    len = $urandom_range(16, 0);
      LkFull:     len = LineSize - 1;
      LkOverflow: len = $urandom_range(LineSize + 6, LineSize);
      LkNoise: begin
        // Raw bytes, newlines and carriage returns included, with no framing.
        n = $urandom_range(6, 1);
        repeat (n) send_byte(8'($urandom_range(255)));
        return;
      end
      default: len = 0;
    endcase
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_byte(ChCr);
      send_byte(text_byte());
    end
    if ($urandom_range(2) == 0) send_byte(ChCr);
    send_byte(ChLf);
  endtask

  task automatic run_random(input int unsigned snd_pct, input int unsigned rcv_pct,
                            input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 5)       send_line(LkFull);
      else if (pick < 10) send_line(LkOverflow);
      else if (pick < 20) send_line(LkNoise);
      else                send_line(LkShort);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty lines, bare carriage returns, extreme byte values.
    send_byte(ChLf);
    send_byte(ChCr);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChCr);
    send_byte(8'h7F);
    send_byte(ChLf);
    send_byte(8'h41);
    send_byte(ChLf);
    // Longest line that fits, then one that overflows and a newline that ends discard.
    send_line(LkFull);
    send_line(LkOverflow);
    send_byte(ChLf);
    send_byte(8'h80);
    send_byte(ChLf);

    run_random(35, 66, 30);
    run_random(66, 35, 30);
    run_random(0, 0, 30);

    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending_chars.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d bytes besides carriage returns, checked %0d chars in %0d lines",
             items_sent, tracker.chars_checked, tracker.lines_done);
    $display("lines dropped for length: %0d", tracker.ovf_total);
    if (tracker.errors == 0 && tracker.pending_chars.size() == 0) begin
      $display("tb_serial_line_assembler passed");
    end else begin
      $display("tb_serial_line_assembler failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sla_pkg.sv
hw/rtl/sla_queue.sv
hw/rtl/sla_line_buf.sv
hw/rtl/sla_front.sv
hw/rtl/sla_back.sv
hw/rtl/serial_line_assembler.sv
hw/rtl/sla_checker.sv
verif/tb_serial_line_assembler.sv
